@@ rtl/zcpd_pkg.sv @@
package zcpd_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pulse_word;
    logic [2:0]  channel_number;
    logic [31:0] pulse_time;
    logic        pulse_first;
    logic        pulse_last;
    logic        pulse_empty;
  } out_item_t;

  localparam logic [11:0] HEADER_TAG   = 12'hA00;
  localparam logic [3:0]  CTRL_NIBBLE  = 4'h8;
  localparam int          MASK_BITS    = 8;

endpackage

@@ rtl/zcpd_parser.sv @@
module zcpd_parser #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  zcpd_pkg::in_item_t  in_item,
  output logic                res_valid,
  output zcpd_pkg::out_item_t res_item
);
  import zcpd_pkg::*;

  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SIZE   = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_GOOD   = 3'd4;

  localparam logic [MASK_BITS-1:0] CH_MASK =
    MASK_BITS'((16'd1 << NUM_CHANNELS) - 16'd1);

  // Index of the lowest set bit; only called with a nonzero argument.
  function automatic logic [2:0] lowest_set(input logic [MASK_BITS-1:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = MASK_BITS - 1; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           hpos_r, hpos_nxt;
  logic [MASK_BITS-1:0] pending_r, pending_nxt;
  logic [2:0]           cur_r, cur_nxt;
  logic [30:0]          etime_r, etime_nxt;
  logic [31:0]          offset_r, offset_nxt;
  logic [31:0]          total_r, total_nxt;
  logic [31:0]          seen_r, seen_nxt;
  logic [27:0]          left_r, left_nxt;
  logic [27:0]          runlen_r, runlen_nxt;

  logic                 do_check, do_pick;
  logic [MASK_BITS-1:0] pick_src;
  logic [27:0]          good_cnt, left_dec;
  logic [31:0]          w;
  logic [31:0]          time_now;

  assign w        = in_item.data_word;
  assign good_cnt = w[27:0];
  assign left_dec = (left_r != 28'd0) ? left_r - 28'd1 : 28'd0;
  assign time_now = {1'b0, etime_r} + offset_r;

  always_comb begin
    phase_nxt   = phase_r;
    hpos_nxt    = hpos_r;
    pending_nxt = pending_r;
    cur_nxt     = cur_r;
    etime_nxt   = etime_r;
    offset_nxt  = offset_r;
    total_nxt   = total_r;
    seen_nxt    = seen_r;
    left_nxt    = left_r;
    runlen_nxt  = runlen_r;
    do_check    = 1'b0;
    do_pick     = 1'b0;
    pick_src    = pending_r;

    res_valid                = 1'b0;
    res_item.pulse_word      = w;
    res_item.channel_number  = cur_r;
    res_item.pulse_time      = time_now;
    res_item.pulse_first     = 1'b0;
    res_item.pulse_last      = 1'b0;
    res_item.pulse_empty     = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (hpos_r == 2'd1) begin
          pending_nxt = w[MASK_BITS-1:0] & CH_MASK;
          hpos_nxt    = 2'd2;
        end else if (hpos_r == 2'd2) begin
          hpos_nxt = 2'd3;
        end else begin
          etime_nxt = w[30:0];
          hpos_nxt  = 2'd0;
          do_pick   = 1'b1;
        end
      end
      PH_SIZE: begin
        total_nxt  = w;
        seen_nxt   = 32'd1;
        offset_nxt = 32'd0;
        do_check   = 1'b1;
      end
      PH_DATA: begin
        if (w[31:28] != CTRL_NIBBLE) begin
          // Skip word: the offset advances by two samples per count.
          offset_nxt = offset_r + {w[30:0], 1'b0};
          seen_nxt   = seen_r + 32'd1;
          do_check   = 1'b1;
        end else begin
          seen_nxt = seen_r + 32'd1 + {4'd0, good_cnt};
          if (good_cnt == 28'd0) begin
            res_valid            = 1'b1;
            res_item.pulse_word  = 32'd0;
            res_item.pulse_first = 1'b1;
            res_item.pulse_last  = 1'b1;
            res_item.pulse_empty = 1'b1;
            do_check             = 1'b1;
          end else begin
            left_nxt   = good_cnt;
            runlen_nxt = good_cnt;
            phase_nxt  = PH_GOOD;
          end
        end
      end
      PH_GOOD: begin
        res_valid            = 1'b1;
        res_item.pulse_first = (left_r == runlen_r);
        res_item.pulse_last  = (left_r <= 28'd1);
        left_nxt             = left_dec;
        if (left_dec == 28'd0) begin
          offset_nxt = offset_r + {3'd0, runlen_r, 1'b0};
          do_check   = 1'b1;
        end
      end
      default: begin
        if (w[31:20] == HEADER_TAG) begin
          phase_nxt = PH_HEADER;
          hpos_nxt  = 2'd1;
        end else begin
          phase_nxt = PH_SEEK;
        end
      end
    endcase

    // When a channel's words are all seen, drop its mask bit and pick the next one.
    if (do_check) begin
      if (seen_nxt < total_nxt) begin
        phase_nxt = PH_DATA;
      end else begin
        pick_src = pending_r & ~(MASK_BITS'(1) << cur_r);
        do_pick  = 1'b1;
      end
    end

    if (do_pick) begin
      pick_src    = pick_src & CH_MASK;
      pending_nxt = pick_src;
      if (pick_src == '0) begin
        phase_nxt = PH_SEEK;
        hpos_nxt  = 2'd0;
      end else begin
        cur_nxt   = lowest_set(pick_src);
        phase_nxt = PH_SIZE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_take && in_item.end_of_block)) begin
      phase_r   <= PH_SEEK;
      hpos_r    <= 2'd0;
      pending_r <= '0;
      cur_r     <= 3'd0;
      etime_r   <= 31'd0;
      offset_r  <= 32'd0;
      total_r   <= 32'd0;
      seen_r    <= 32'd0;
      left_r    <= 28'd0;
      runlen_r  <= 28'd0;
    end else if (in_take) begin
      phase_r   <= phase_nxt;
      hpos_r    <= hpos_nxt;
      pending_r <= pending_nxt;
      cur_r     <= cur_nxt;
      etime_r   <= etime_nxt;
      offset_r  <= offset_nxt;
      total_r   <= total_nxt;
      seen_r    <= seen_nxt;
      left_r    <= left_nxt;
      runlen_r  <= runlen_nxt;
    end
  end

endmodule

@@ rtl/zcpd_out_buf.sv @@
module zcpd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  zcpd_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output zcpd_pkg::out_item_t out_item
);
  import zcpd_pkg::*;

  logic      main_v_r, skid_v_r;
  out_item_t main_d_r, skid_d_r;
  logic      pop;

  assign pop       = main_v_r && !out_stall;
  assign out_valid = main_v_r;
  assign out_item  = main_d_r;
  // The upstream side only pushes while the skid slot is empty.
  assign full      = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop && skid_v_r) begin
        main_d_r <= skid_d_r;
        skid_v_r <= 1'b0;
      end else if (pop) begin
        main_v_r <= push;
        if (push) main_d_r <= push_item;
      end else if (push) begin
        if (main_v_r) begin
          skid_d_r <= push_item;
          skid_v_r <= 1'b1;
        end else begin
          main_d_r <= push_item;
          main_v_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/zle_channel_pulse_deframer_top.sv @@
// Zero-length-encoded pulse deframer: takes one 32-bit readout word per item,
// finds event headers, walks the channel mask in ascending order and emits one
// item per good sample word (or one empty marker for a zero-length run), each
// tagged with channel, header time plus sample offset, and first/last marks.
// The parse step is a single pass of logic from the input port into the state
// registers and a two-entry output buffer, so one item is accepted per clock
// while the output buffer has a free entry; each result is registered in the
// output buffer before it appears on the output. The input stalls only when
// both output buffer entries are full. end_of_block returns the parser to
// seeking after its word is processed.
module zle_channel_pulse_deframer_top #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  zcpd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output zcpd_pkg::out_item_t out_item
);
  import zcpd_pkg::*;

  logic      in_take;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  assign in_stall = buf_full;
  assign in_take  = in_valid && !buf_full;

  zcpd_parser #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  zcpd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take && res_valid),
    .push_item(res_item),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  a_full_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry held while output entry is empty");

  a_full_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && out_stall) |=> in_stall)
    else $error("skid entry drained while output was stalled");

  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_item.pulse_empty) |-> (res_item.pulse_first && res_item.pulse_last))
    else $error("empty marker without first and last marks");

  a_accept_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("input stalled right after the output drained");

endmodule
